// File: src/upt_pkg.sv
// Shared types and codes for the UDP port table demultiplexer.
package upt_pkg;

   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_CLOSE   = 3'd1;
   localparam logic [2:0] ACT_BIND    = 3'd2;
   localparam logic [2:0] ACT_CONNECT = 3'd3;
   localparam logic [2:0] ACT_SEND    = 3'd4;
   localparam logic [2:0] ACT_DELIVER = 3'd5;
   localparam logic [2:0] ACT_RECEIVE = 3'd6;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_REJECT   = 3'd1;
   localparam logic [2:0] ST_NO_MATCH = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   localparam logic [2:0] CSR_HOST_IP    = 3'd0;
   localparam logic [2:0] CSR_EPH_FIRST  = 3'd1;
   localparam logic [2:0] CSR_EPH_LAST   = 3'd2;
   localparam logic [2:0] CSR_QUEUE_LIM  = 3'd3;
   localparam logic [2:0] CSR_MAX_PAYLD  = 3'd4;

   localparam logic [31:0] HOST_IP_RST   = 32'd167772687;
   localparam logic [15:0] EPH_FIRST_RST = 16'd49152;
   localparam logic [15:0] EPH_LAST_RST  = 16'd65535;
   localparam logic [4:0]  QUEUE_LIM_RST = 5'd16;
   localparam logic [15:0] MAX_PAYLD_RST = 16'd1472;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  socket_slot;
      logic [31:0] address_ip;
      logic [15:0] address_port;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic        has_destination;
      logic [15:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  result_slot;
      logic [15:0] send_source_port;
      logic [31:0] send_dest_ip;
      logic [15:0] send_dest_port;
   } rsp_type;

endpackage

// File: src/upt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module upt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/udp_port_table_demux.sv
// UDP port table demultiplexer: endpoint table, port allocation and datagram classification.
// Flow: alloc, close, unknown action and precheck rejects answer straight from dispatch;
//   receive skips the write-back on an empty queue; deliver reads slot by slot until a
//   match or the last slot; bind to a given port scans the slots for a clash; automatic
//   binding repeats that scan for each port tried, as the port-in-use scan walks the
//   single-read-port entry RAM one slot at a time.
// Throughput: one beat at a time; req_stall drops as rsp_valid rises.
// Reset: synchronous; slot flags clear, registers and next ephemeral port take reset values.
module udp_port_table_demux import upt_pkg::*; #(
   parameter int SOCKET_COUNT    = 16,
   parameter int QUEUE_COUNT_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(SOCKET_COUNT);
   localparam int CNT_W = $clog2(QUEUE_COUNT_MAX + 1);
   localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOCKET_COUNT - 1);

   // one RAM row per slot; flags live in flops so reset clears them at once
   typedef struct packed {
      logic [31:0]      bind_ip;
      logic [15:0]      bind_port;
      logic [31:0]      peer_ip;
      logic [15:0]      peer_port;
      logic [CNT_W-1:0] queue_count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_LOAD, S_AB_CHK, S_AB_TRY, S_PF_RD, S_PF_CK,
      S_FINISH, S_DV_RD, S_DV_CK, S_WB, S_RESP
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   entry_type         entry_ff, entry_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [15:0]       pf_port_ff, pf_port_in;
   logic              ab_mode_ff, ab_mode_in;
   logic [16:0]       tries_ff, tries_in;
   logic [16:0]       try_n_ff, try_n_in;
   logic [15:0]       next_eph_ff, next_eph_in;
   logic [SOCKET_COUNT-1:0] used_ff, used_in;
   logic [SOCKET_COUNT-1:0] bound_ff, bound_in;
   logic [SOCKET_COUNT-1:0] conn_ff, conn_in;
   logic [31:0]       host_ip_ff, host_ip_in;
   logic [15:0]       eph_first_ff, eph_first_in;
   logic [15:0]       eph_last_ff, eph_last_in;
   logic [4:0]        queue_lim_ff, queue_lim_in;
   logic [15:0]       max_payld_ff, max_payld_in;

   // entry RAM port
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr, mem_raddr;
   entry_type         mem_wdata, mem_rdata;
   logic [ENTRY_W-1:0] mem_rdata_raw;

   // decode helpers
   logic [IDX_W-1:0]  slot_s;
   logic              in_range;
   logic              free_found;
   logic [IDX_W-1:0]  free_idx;
   logic [LIM_W-1:0]  q_limit;
   logic [15:0]       eph_cand;
   logic [16:0]       eph_inc;
   logic              taken;
   logic              dv_match;
   logic [31:0]       tgt_ip;
   logic [15:0]       tgt_port;

   upt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SOCKET_COUNT)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata_raw)
   );

   assign mem_rdata = entry_type'(mem_rdata_raw);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign slot_s   = IDX_W'(req_ff.socket_slot);
   assign in_range = ({3'b000, req_ff.socket_slot} < 7'(SOCKET_COUNT));

   // effective queue limit: smaller of register and build-time cap
   assign q_limit = (LIM_W'(queue_lim_ff) < LIM_W'(QUEUE_COUNT_MAX)) ?
                    LIM_W'(queue_lim_ff) : LIM_W'(QUEUE_COUNT_MAX);

   // ephemeral candidate: restart at first when out of range, wrap after last
   assign eph_cand = (next_eph_ff < eph_first_ff || next_eph_ff > eph_last_ff) ?
                     eph_first_ff : next_eph_ff;
   assign eph_inc  = {1'b0, eph_cand} + 17'd1;

   // port held by some other bound slot
   assign taken = (scan_ff != slot_s) && used_ff[scan_ff] && bound_ff[scan_ff] &&
                  (mem_rdata.bind_port == pf_port_ff);

   // datagram classification against the row under scan
   assign dv_match = used_ff[scan_ff] && bound_ff[scan_ff] &&
                     (mem_rdata.bind_port == req_ff.address_port) &&
                     (mem_rdata.bind_ip == 32'd0 ||
                      mem_rdata.bind_ip == req_ff.address_ip) &&
                     (!conn_ff[scan_ff] ||
                      (mem_rdata.peer_ip == req_ff.source_ip &&
                       mem_rdata.peer_port == req_ff.source_port));

   // send target: explicit or connected peer
   assign tgt_ip   = req_ff.has_destination ? req_ff.address_ip   : entry_ff.peer_ip;
   assign tgt_port = req_ff.has_destination ? req_ff.address_port : entry_ff.peer_port;

   // first unused slot for alloc
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = SOCKET_COUNT - 1; k >= 0; k--) begin
         if (!used_ff[k]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      entry_in     = entry_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      scan_in      = scan_ff;
      pf_port_in   = pf_port_ff;
      ab_mode_in   = ab_mode_ff;
      tries_in     = tries_ff;
      try_n_in     = try_n_ff;
      next_eph_in  = next_eph_ff;
      used_in      = used_ff;
      bound_in     = bound_ff;
      conn_in      = conn_ff;
      host_ip_in   = host_ip_ff;
      eph_first_in = eph_first_ff;
      eph_last_in  = eph_last_ff;
      queue_lim_in = queue_lim_ff;
      max_payld_in = max_payld_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_s;
      mem_wdata    = entry_ff;
      mem_raddr    = slot_s;

      if (csr_valid) begin
         case (csr_index)
            CSR_HOST_IP:   host_ip_in   = csr_wdata;
            CSR_EPH_FIRST: eph_first_in = csr_wdata[15:0];
            CSR_EPH_LAST:  eph_last_in  = csr_wdata[15:0];
            CSR_QUEUE_LIM: queue_lim_in = csr_wdata[4:0];
            CSR_MAX_PAYLD: max_payld_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               res_in        = '0;
               res_in.status = ST_REJECT;
               state_in      = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            state_in = S_RESP;
            case (req_ff.action)
               ACT_ALLOC: begin
                  if (free_found) begin
                     mem_we             = 1'b1;
                     mem_waddr          = free_idx;
                     mem_wdata          = '0;
                     used_in[free_idx]  = 1'b1;
                     bound_in[free_idx] = 1'b0;
                     conn_in[free_idx]  = 1'b0;
                     res_in.status      = ST_DONE;
                     res_in.result_slot = 4'(free_idx);
                  end
               end
               ACT_CLOSE: begin
                  if (in_range) begin
                     mem_we           = 1'b1;
                     mem_wdata        = '0;
                     used_in[slot_s]  = 1'b0;
                     bound_in[slot_s] = 1'b0;
                     conn_in[slot_s]  = 1'b0;
                     res_in.status    = ST_DONE;
                  end
               end
               ACT_BIND: begin
                  if (in_range && used_ff[slot_s] && !bound_ff[slot_s] &&
                      (req_ff.address_ip == 32'd0 || req_ff.address_ip == host_ip_ff)) begin
                     state_in = S_LOAD;
                  end
               end
               ACT_CONNECT: begin
                  if (in_range && used_ff[slot_s] && req_ff.address_ip != 32'd0 &&
                      req_ff.address_port != 16'd0) begin
                     state_in = S_LOAD;
                  end
               end
               ACT_SEND: begin
                  if (in_range && used_ff[slot_s] &&
                      req_ff.payload_length <= max_payld_ff) begin
                     state_in = S_LOAD;
                  end
               end
               ACT_RECEIVE: begin
                  if (in_range && used_ff[slot_s]) begin
                     state_in = S_LOAD;
                  end
               end
               ACT_DELIVER: begin
                  res_in.status = ST_NO_MATCH;
                  scan_in       = '0;
                  state_in      = S_DV_RD;
               end
               default: ;
            endcase
         end

         S_LOAD: begin
            entry_in = mem_rdata;
            case (req_ff.action)
               ACT_BIND: begin
                  if (req_ff.address_port == 16'd0) begin
                     state_in = S_AB_CHK;
                  end else begin
                     pf_port_in = req_ff.address_port;
                     ab_mode_in = 1'b0;
                     scan_in    = '0;
                     state_in   = S_PF_RD;
                  end
               end
               ACT_RECEIVE: begin
                  if (mem_rdata.queue_count == '0) begin
                     res_in.status = ST_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     entry_in.queue_count = mem_rdata.queue_count - CNT_W'(1);
                     res_in.status        = ST_DONE;
                     res_in.result_slot   = req_ff.socket_slot;
                     state_in             = S_WB;
                  end
               end
               default: state_in = S_AB_CHK;
            endcase
         end

         S_AB_CHK: begin
            if (bound_ff[slot_s]) begin
               state_in = S_FINISH;
            end else if (eph_first_ff > eph_last_ff) begin
               state_in = S_RESP;
            end else begin
               tries_in = {1'b0, eph_last_ff} - {1'b0, eph_first_ff} + 17'd1;
               try_n_in = '0;
               state_in = S_AB_TRY;
            end
         end

         S_AB_TRY: begin
            if (try_n_ff == tries_ff) begin
               state_in = S_RESP;
            end else begin
               try_n_in    = try_n_ff + 17'd1;
               next_eph_in = (eph_inc > {1'b0, eph_last_ff}) ? eph_first_ff : eph_inc[15:0];
               if (eph_cand != 16'd0) begin
                  pf_port_in = eph_cand;
                  ab_mode_in = 1'b1;
                  scan_in    = '0;
                  state_in   = S_PF_RD;
               end
            end
         end

         S_PF_RD: begin
            mem_raddr = scan_ff;
            state_in  = S_PF_CK;
         end

         S_PF_CK: begin
            if (taken) begin
               state_in = ab_mode_ff ? S_AB_TRY : S_RESP;
            end else if (scan_ff == LAST_IDX) begin
               bound_in[slot_s]   = 1'b1;
               entry_in.bind_port = pf_port_ff;
               // automatic binding leaves the wildcard address; bind sets its own later
               entry_in.bind_ip   = ab_mode_ff ? 32'd0 : req_ff.address_ip;
               if (ab_mode_ff) begin
                  state_in = S_FINISH;
               end else begin
                  res_in.status = ST_DONE;
                  state_in      = S_WB;
               end
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = S_PF_RD;
            end
         end

         // autobound or already bound: finish bind, connect or send
         S_FINISH: begin
            state_in = S_WB;
            case (req_ff.action)
               ACT_BIND: begin
                  entry_in.bind_ip = req_ff.address_ip;
                  res_in.status    = ST_DONE;
               end
               ACT_CONNECT: begin
                  conn_in[slot_s]    = 1'b1;
                  entry_in.peer_ip   = req_ff.address_ip;
                  entry_in.peer_port = req_ff.address_port;
                  res_in.status      = ST_DONE;
               end
               ACT_SEND: begin
                  // binding stays even when the send itself is refused
                  if ((req_ff.has_destination || conn_ff[slot_s]) &&
                      tgt_ip != 32'd0 && tgt_port != 16'd0) begin
                     res_in.status           = ST_DONE;
                     res_in.send_source_port = entry_ff.bind_port;
                     res_in.send_dest_ip     = tgt_ip;
                     res_in.send_dest_port   = tgt_port;
                  end
               end
               default: ;
            endcase
         end

         S_DV_RD: begin
            mem_raddr = scan_ff;
            state_in  = S_DV_CK;
         end

         S_DV_CK: begin
            if (dv_match) begin
               res_in.result_slot = 4'(scan_ff);
               state_in           = S_RESP;
               if (LIM_W'(mem_rdata.queue_count) < q_limit) begin
                  mem_we                = 1'b1;
                  mem_waddr             = scan_ff;
                  mem_wdata             = mem_rdata;
                  mem_wdata.queue_count = mem_rdata.queue_count + CNT_W'(1);
                  res_in.status         = ST_DONE;
               end else begin
                  res_in.status = ST_FULL;
               end
            end else if (scan_ff == LAST_IDX) begin
               state_in = S_RESP;
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = S_DV_RD;
            end
         end

         S_WB: begin
            mem_we   = 1'b1;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      entry_ff    <= entry_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      scan_ff     <= scan_in;
      pf_port_ff  <= pf_port_in;
      ab_mode_ff  <= ab_mode_in;
      tries_ff    <= tries_in;
      try_n_ff    <= try_n_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         next_eph_ff  <= EPH_FIRST_RST;
         used_ff      <= '0;
         bound_ff     <= '0;
         conn_ff      <= '0;
         host_ip_ff   <= HOST_IP_RST;
         eph_first_ff <= EPH_FIRST_RST;
         eph_last_ff  <= EPH_LAST_RST;
         queue_lim_ff <= QUEUE_LIM_RST;
         max_payld_ff <= MAX_PAYLD_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         next_eph_ff  <= next_eph_in;
         used_ff      <= used_in;
         bound_ff     <= bound_in;
         conn_ff      <= conn_in;
         host_ip_ff   <= host_ip_in;
         eph_first_ff <= eph_first_in;
         eph_last_ff  <= eph_last_in;
         queue_lim_ff <= queue_lim_in;
         max_payld_ff <= max_payld_in;
      end
   end

endmodule
